@@ hdl/mtwq_pkg.sv @@
// Shared types, constants and codes for the mutex table with wait queues.
`timescale 1ns / 1ps

package mtwq_pkg;

  // Table dimensions.
  localparam int NUM_MUTEXES = 32;
  localparam int NUM_TASKS   = 64;

  // Index widths that follow from the table dimensions.
  localparam int MUTEX_W = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int TASK_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Fixed port widths.
  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 3;
  localparam int CID_W    = 5;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Command codes on the input port.
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

  // Operation after classification by the front.
  typedef enum logic [1:0] {
    OP_CREATE,
    OP_LOCK,
    OP_UNLOCK,
    OP_BAD
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_NOFREE   = 3'd2,
    ST_INVALID  = 3'd3,
    ST_DEADLOCK = 3'd4,
    ST_NOTOWNER = 3'd5
  } status_e;

  // Classified command word passed from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [MUTEX_W-1:0] mutex_idx;
    logic [TASK_W-1:0]  task_idx;
  } item_t;

  // Result word produced by the back.
  typedef struct packed {
    status_e          status;
    logic [CID_W-1:0] created_id;
    logic             woken_valid;
    logic [ID_W-1:0]  woken_task;
  } result_t;

endpackage

@@ hdl/mtwq_front.sv @@
// Front stage: accepts command words, range-checks and classifies them.
`timescale 1ns / 1ps

module mtwq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mtwq_pkg::CMD_W-1:0]  cmd_i,
  input  logic [mtwq_pkg::ID_W-1:0]   mutex_id_i,
  input  logic [mtwq_pkg::ID_W-1:0]   task_id_i,
  output logic                        push_o,
  input  logic                        push_ready_i,
  output mtwq_pkg::item_t             item_o
);
  import mtwq_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  ids_ok;
  logic  accept;

  // Ids outside the table or the task range make lock and unlock invalid.
  assign ids_ok = ({1'b0, mutex_id_i} < (ID_W + 1)'(NUM_MUTEXES)) &&
                  ({1'b0, task_id_i} < (ID_W + 1)'(NUM_TASKS));

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the incoming word.
  always_comb begin
    item_d.mutex_idx = MUTEX_W'(mutex_id_i);
    item_d.task_idx  = TASK_W'(task_id_i);
    case (cmd_i)
      CMD_CREATE: item_d.op = OP_CREATE;
      CMD_LOCK:   item_d.op = ids_ok ? OP_LOCK : OP_BAD;
      CMD_UNLOCK: item_d.op = ids_ok ? OP_UNLOCK : OP_BAD;
      default:    item_d.op = OP_BAD;
    endcase
  end

  // Holding register in front of the queue.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign push_o = valid_q;
  assign item_o = item_q;

endmodule

@@ hdl/mtwq_fifo.sv @@
// Short queue of classified command words between the front and the back.
`timescale 1ns / 1ps

module mtwq_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  mtwq_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output mtwq_pkg::item_t pop_item_o
);
  import mtwq_pkg::*;

  item_t                 entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = entries_q[rd_ptr_q];

  // Pointer and count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hdl/mtwq_back.sv @@
// Back end: holds the mutex table and wait queues and executes each command word.
`timescale 1ns / 1ps

module mtwq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_o,
  input  mtwq_pkg::item_t   item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtwq_pkg::result_t result_o
);
  import mtwq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e  state_q, state_d;
  item_t   item_q, item_d;
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;

  // Per-mutex flags, cleared at reset.
  logic [NUM_MUTEXES-1:0] created_q, created_d;
  logic [NUM_MUTEXES-1:0] locked_q, locked_d;
  logic [NUM_MUTEXES-1:0] wait_q, wait_d;

  // Per-mutex pointers, defined once written.
  logic [TASK_W-1:0] owner_q [NUM_MUTEXES];
  logic [TASK_W-1:0] head_q [NUM_MUTEXES];
  logic [TASK_W-1:0] tail_q [NUM_MUTEXES];

  // Next-waiter links, one per task, with a registered read port.
  logic [TASK_W-1:0] next_mem [NUM_TASKS];
  logic [TASK_W-1:0] next_rd_q;

  logic               exec;
  logic               free_found;
  logic [MUTEX_W-1:0] free_idx;
  logic [MUTEX_W-1:0] m;
  logic [TASK_W-1:0]  t;
  logic               owner_we, head_we, tail_we, link_we;
  logic [TASK_W-1:0]  owner_wd, head_wd;

  assign m      = item_q.mutex_idx;
  assign t      = item_q.task_idx;
  assign pop_o  = (state_q == S_IDLE);
  assign exec   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Lowest mutex that has not been created yet.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_MUTEXES - 1; i >= 0; i--) begin
      if (!created_q[i]) begin
        free_found = 1'b1;
        free_idx   = MUTEX_W'(i);
      end
    end
  end

  // Command execution on the registered word and the registered link read.
  always_comb begin
    created_d = created_q;
    locked_d  = locked_q;
    wait_d    = wait_q;
    owner_we  = 1'b0;
    head_we   = 1'b0;
    tail_we   = 1'b0;
    link_we   = 1'b0;
    owner_wd  = t;
    head_wd   = t;
    result_d  = '{status: ST_INVALID, created_id: '0, woken_valid: 1'b0, woken_task: '0};
    case (item_q.op)
      OP_CREATE: begin
        if (free_found) begin
          created_d[free_idx] = 1'b1;
          result_d.status     = ST_OK;
          result_d.created_id = CID_W'(free_idx);
        end else begin
          result_d.status = ST_NOFREE;
        end
      end
      OP_LOCK: begin
        if (created_q[m]) begin
          if (!locked_q[m]) begin
            locked_d[m]     = 1'b1;
            owner_we        = 1'b1;
            result_d.status = ST_OK;
          end else if (owner_q[m] == t) begin
            result_d.status = ST_DEADLOCK;
          end else begin
            // Append the caller to the tail of the wait queue.
            tail_we         = 1'b1;
            result_d.status = ST_QUEUED;
            if (wait_q[m]) begin
              link_we = 1'b1;
            end else begin
              head_we   = 1'b1;
              wait_d[m] = 1'b1;
            end
          end
        end
      end
      OP_UNLOCK: begin
        if (created_q[m]) begin
          if (!locked_q[m] || owner_q[m] != t) begin
            result_d.status = ST_NOTOWNER;
          end else if (!wait_q[m]) begin
            locked_d[m]     = 1'b0;
            result_d.status = ST_OK;
          end else begin
            // Hand ownership to the head waiter and advance the queue.
            owner_we             = 1'b1;
            owner_wd             = head_q[m];
            result_d.status      = ST_OK;
            result_d.woken_valid = 1'b1;
            result_d.woken_task  = ID_W'(head_q[m]);
            if (head_q[m] == tail_q[m]) begin
              wait_d[m] = 1'b0;
            end else begin
              head_we = 1'b1;
              head_wd = next_rd_q;
            end
          end
        end
      end
      default: begin
        result_d.status = ST_INVALID;
      end
    endcase
  end

  // Sequencer: take a word, then update once the output register is free.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          item_d  = item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '{op: OP_BAD, mutex_idx: '0, task_idx: '0};
      out_valid_q <= 1'b0;
      result_q    <= '{status: ST_OK, created_id: '0, woken_valid: 1'b0, woken_task: '0};
      created_q   <= '0;
      locked_q    <= '0;
      wait_q      <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        result_q  <= result_d;
        created_q <= created_d;
        locked_q  <= locked_d;
        wait_q    <= wait_d;
      end
    end
  end

  // Pointer tables.
  always_ff @(posedge clk_i) begin
    if (exec && owner_we) begin
      owner_q[m] <= owner_wd;
    end
    if (exec && head_we) begin
      head_q[m] <= head_wd;
    end
    if (exec && tail_we) begin
      tail_q[m] <= t;
    end
  end

  // Link memory: written at the old tail, read at the head when a word is taken.
  always_ff @(posedge clk_i) begin
    if (exec && link_we) begin
      next_mem[tail_q[m]] <= t;
    end
    if (state_q == S_IDLE) begin
      next_rd_q <= next_mem[head_q[item_i.mutex_idx]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef SYNTH
  // Only a created mutex can be locked.
  a_locked_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (locked_q & ~created_q) == '0)
    else $error("locked mutex that was never created");

  // A mutex with waiters is always held.
  a_wait_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_q & ~locked_q) == '0)
    else $error("waiters on a free mutex");

  // A woken task is only reported with a successful status.
  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.woken_valid |-> result_q.status == ST_OK)
    else $error("woken task reported with an error status");

  // A pending update waits while the previous result is still held.
  a_exec_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && out_valid_q && !out_ready_i |=> state_q == S_EXEC)
    else $error("update overran an unread result");
`endif

endmodule

@@ hdl/mutex_table_with_wait_queues_unit.sv @@
// Top level of the mutex table with FIFO wait queues.
`timescale 1ns / 1ps
// Flow: an accepted word passes the front register and the queue; the back end then
//   takes it into its word register along with a registered read of the next-waiter
//   link memory, and updates the table once its output register is free. The back end
//   takes no new word until that update is done.
// Reset: asynchronous, active low; clears the created, locked and waiter flags and all
//   handshake state. Pointer tables are not cleared and no clearing pass is needed.

module mutex_table_with_wait_queues_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mtwq_pkg::CMD_W-1:0]    cmd_i,
  input  logic [mtwq_pkg::ID_W-1:0]     mutex_id_i,
  input  logic [mtwq_pkg::ID_W-1:0]     task_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtwq_pkg::STATUS_W-1:0] status_o,
  output logic [mtwq_pkg::CID_W-1:0]    created_id_o,
  output logic                          woken_valid_o,
  output logic [mtwq_pkg::ID_W-1:0]     woken_task_o
);
  import mtwq_pkg::*;

  logic    push, push_ready;
  item_t   push_item;
  logic    pop_valid, pop;
  item_t   pop_item;
  result_t result;

  // Accept and classify.
  mtwq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .mutex_id_i   (mutex_id_i),
    .task_id_i    (task_id_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  // Decoupling queue.
  mtwq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  // Execute against the mutex table.
  mtwq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o      = result.status;
  assign created_id_o  = result.created_id;
  assign woken_valid_o = result.woken_valid;
  assign woken_task_o  = result.woken_task;

endmodule
